[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/psc_pkg.sv]
`default_nettype none

package psc_pkg;

  // input commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_THROW = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  // throw order requests
  localparam logic [1:0] REQ_NORMAL = 2'd0;
  localparam logic [1:0] REQ_THROWN = 2'd1;

  // reported point states
  typedef enum logic [1:0] {
    ST_THROWN = 2'd0,
    ST_NORMAL = 2'd1,
    ST_MOVING = 2'd2
  } pstate_t;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_NORMAL = 2'd0;
  localparam logic [1:0] CFG_THROWN = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;

  // reset values
  localparam logic [7:0] RST_NORMAL  = 8'd20;
  localparam logic [7:0] RST_THROWN  = 8'd150;
  localparam logic [9:0] RST_PERIOD  = 10'd30;
  localparam logic [7:0] RST_CURRENT = 8'd21;

  // job queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // one result item
  typedef struct packed {
    logic       kind;
    logic [1:0] state;
    logic [7:0] angle;
  } res_t;

  // results caused by one input, slot 0 first
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       res;
  } job_t;

  // configuration write
  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [9:0] data;
  } cfg_wr_t;

  // queue write side
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // queue read side
  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

`default_nettype wire

[hdl/psc_front.sv]
`default_nettype none

module psc_front
  import psc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  input  wire logic    in_valid,
  input  wire logic [1:0] in_cmd,
  input  wire logic [1:0] in_req,
  input  wire logic    q_full,
  output logic         in_ready,
  output q_wr_t        q_wr
);

  logic [7:0] normal_r, thrown_r, target_r, current_r;
  logic [9:0] period_r, elapsed_r;
  logic [7:0] target_nxt, current_nxt;
  logic [9:0] elapsed_nxt;
  job_t       job;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the transaction and build its results
  always_comb begin
    logic [7:0] stepped;
    logic       leaving, arrive;
    res_t       r_move, r_write, r_arrive, r_query;
    stepped     = '0;
    leaving     = 1'b0;
    arrive      = 1'b0;
    target_nxt  = target_r;
    current_nxt = current_r;
    elapsed_nxt = elapsed_r;
    job         = '0;

    r_query.kind  = KIND_STATUS;
    r_query.angle = '0;
    if (current_r == normal_r) begin
      r_query.state = ST_NORMAL;
    end else if (current_r == thrown_r) begin
      r_query.state = ST_THROWN;
    end else begin
      r_query.state = ST_MOVING;
    end

    r_move.kind  = KIND_STATUS;
    r_move.state = ST_MOVING;
    r_move.angle = '0;

    stepped = (target_r > current_r) ? current_r + 8'd1 : current_r - 8'd1;
    r_write.kind  = KIND_WRITE;
    r_write.state = ST_THROWN;
    r_write.angle = stepped;

    r_arrive.kind  = KIND_STATUS;
    r_arrive.state = (target_r == thrown_r) ? ST_THROWN : ST_NORMAL;
    r_arrive.angle = '0;

    unique case (cmd_t'(in_cmd))
      CMD_THROW: begin
        if (in_req == REQ_NORMAL) begin
          target_nxt = normal_r;
        end else if (in_req == REQ_THROWN) begin
          target_nxt = thrown_r;
        end
      end
      CMD_QUERY: begin
        job.cnt    = 2'd1;
        job.res[0] = r_query;
      end
      CMD_TICK: begin
        if (elapsed_r >= period_r) begin
          elapsed_nxt = '0;
          if (current_r != target_r) begin
            leaving     = (current_r == normal_r) || (current_r == thrown_r);
            arrive      = (stepped == target_r);
            current_nxt = stepped;
            // moving report first when leaving an end position
            if (leaving) begin
              job.res[0] = r_move;
              job.res[1] = r_write;
              job.res[2] = r_arrive;
            end else begin
              job.res[0] = r_write;
              job.res[1] = r_arrive;
            end
            job.cnt = 2'd1 + {1'b0, leaving} + {1'b0, arrive};
          end
        end else begin
          elapsed_nxt = elapsed_r + 10'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_wr.push = accept && (job.cnt != 2'd0);
  assign q_wr.job  = job;

  // configuration registers and servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r  <= RST_NORMAL;
      thrown_r  <= RST_THROWN;
      period_r  <= RST_PERIOD;
      target_r  <= RST_NORMAL;
      current_r <= RST_CURRENT;
      elapsed_r <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_NORMAL: normal_r <= cfg.data[7:0];
          CFG_THROWN: thrown_r <= cfg.data[7:0];
          CFG_PERIOD: period_r <= cfg.data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        target_r  <= target_nxt;
        current_r <= current_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/psc_queue.sv]
`default_nettype none

module psc_queue
  import psc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  input  wire logic  pop,
  output logic       full,
  output q_rd_t      q_rd
);

  job_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == Q_CW'(Q_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.job   = mem[rd_ptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_wr.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/psc_back.sv]
`default_nettype none

module psc_back
  import psc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_rd_t q_rd,
  input  wire logic  out_ready,
  output logic       pop,
  output logic       out_valid,
  output res_t       out_res,
  output logic       out_last
);

  job_t       job_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       fire, fire_last;

  assign out_valid = busy_r;
  assign out_res   = job_r.res[idx_r];
  assign out_last  = (idx_r == job_r.cnt - 2'd1);
  assign fire      = busy_r && out_ready;
  assign fire_last = fire && out_last;
  assign pop       = q_rd.valid && (!busy_r || fire_last);

  // job payload
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_rd.job;
    end
  end

  // emit one result a cycle from the held job while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (fire_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else if (fire) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/point_servo_slew_controller.sv]
// Point servo slew controller: moves a point servo one degree per step period.
// Input stream: in_tuser carries the command (tick, throw, query, other),
// in_tdata the throw request. Each input transaction updates the servo state as
// it is taken; in_tready drops only while the four-entry job queue between the
// front and the output stage is full.
// Output stream: one result per cycle while out_tready is high; out_tuser is the
// kind (status or position write), out_tlast marks the final result of its input.
// With the output stage idle, the first result of an input is written to the
// job queue, then loaded into the output stage's job register and driven out.
// Throughput: one input per cycle into the queue while it is not full; the output
// stage emits one result per cycle while out_tready is high, so a stepping tick
// with leave and arrival reports occupies it for three results on the single result port.
// Configuration writes on the cfg_ channel are always ready; the user must make them
// while the block is idle, as the block itself does not enforce this.
// Reset (rst_n low, synchronous) restores the register defaults, empties
// the queue and sets the servo state to its power-up position.
// When the receiver stalls, the held result stays on the port and the
// queue absorbs further inputs until it fills.
`default_nettype none

`include "assert_macros.svh"

module point_servo_slew_controller
  import psc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [1:0] point_request, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [1:0] points_state, [9:2] servo_angle, rest zero
  output logic             out_tuser,  // [0] result_kind
  output logic             out_tlast,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  cfg_wr_t cfg;
  q_wr_t   q_wr;
  q_rd_t   q_rd;
  logic    q_full, q_pop;
  res_t    res;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: accept and classify, update servo state
  psc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_req   (in_tdata[1:0]),
    .q_full   (q_full),
    .in_ready (in_tready),
    .q_wr     (q_wr)
  );

  // job queue
  psc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // back: serialise results
  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .out_ready (out_tready),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, res.angle, res.state};
  assign out_tuser = res.kind;

  // checks
  `PSC_ASSERT_IMP(a_no_accept_when_full, q_full, !in_tready, "input taken with queue full")
  `PSC_ASSERT_NXT(a_job_continues, out_tvalid && out_tready && !out_tlast, out_tvalid, "job ended before its last result")
  `PSC_ASSERT_IMP(a_write_state_zero, out_tvalid && (out_tuser == KIND_WRITE), out_tdata[1:0] == ST_THROWN, "position write with nonzero state")

endmodule

`default_nettype wire
